// File: rtl/core/pqc_pkg.sv
// shared widths, types and codes of the point-in-quad classifier
package pqc_pkg;

   localparam int CoordBits    = 32;
   localparam int SumBits      = CoordBits + 2;
   localparam int OffBits      = CoordBits + 3;
   localparam int AprodBits    = 2 * OffBits;
   localparam int AcrossBits   = AprodBits + 1;
   localparam int DiffBits     = CoordBits + 1;
   localparam int EprodBits    = 2 * DiffBits;
   localparam int CrossBits    = EprodBits + 1;
   localparam int CrossTolBits = 32;
   localparam int CoordTolBits = 16;
   localparam int CsrIndexBits = 1;
   localparam int CsrDataBits  = CrossTolBits;
   localparam int PlaceBits    = 2;
   localparam int Corners      = 4;

   localparam logic [CsrIndexBits-1:0] CsrCrossTol = CsrIndexBits'(0);
   localparam logic [CsrIndexBits-1:0] CsrCoordTol = CsrIndexBits'(1);

   localparam logic [PlaceBits-1:0] PlaceOutside = PlaceBits'(0);
   localparam logic [PlaceBits-1:0] PlaceInside  = PlaceBits'(1);
   localparam logic [PlaceBits-1:0] PlaceOnEdge  = PlaceBits'(2);

   typedef logic signed [CoordBits-1:0] coord_type;
   typedef logic signed [DiffBits-1:0]  diff_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef point_type [Corners-1:0] quad_type;

   typedef struct packed {
      logic [Corners-1:0] on;
      logic [Corners-1:0] pos;
      logic [Corners-1:0] neg;
   } edge_flags_type;

endpackage

// File: rtl/core/pqc_angle_sort.sv
// five-stage pipeline that orders the four corners by angle around their centroid
module pqc_angle_sort (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  pqc_pkg::quad_type  in_quad,
   input  pqc_pkg::point_type in_query,
   output logic               out_valid,
   input  logic               out_ready,
   output pqc_pkg::quad_type  out_quad,
   output pqc_pkg::point_type out_query
);
   import pqc_pkg::*;

   localparam int Stages = 5;
   localparam int Pairs  = 6;
   localparam int PairLo [Pairs] = '{0, 0, 0, 1, 1, 2};
   localparam int PairHi [Pairs] = '{1, 2, 3, 2, 3, 3};

   typedef enum logic [1:0] {
      HalfLow  = 2'd0,
      HalfZero = 2'd1,
      HalfHigh = 2'd2
   } half_type;

   typedef logic signed [SumBits-1:0]    sum_type;
   typedef logic signed [OffBits-1:0]    off_type;
   typedef logic signed [AprodBits-1:0]  aprod_type;
   typedef logic signed [AcrossBits-1:0] across_type;

   logic [Stages-1:0] v_ff;
   logic [Stages:0]   rdy;

   // stage 1: sums
   quad_type  quad1_ff;
   point_type query1_ff;
   sum_type   sumx1_ff, sumx1_in;
   sum_type   sumy1_ff, sumy1_in;
   // stage 2: offsets scaled by four
   quad_type  quad2_ff;
   point_type query2_ff;
   off_type   offx2_ff [Corners];
   off_type   offy2_ff [Corners];
   off_type   offx2_in [Corners];
   off_type   offy2_in [Corners];
   // stage 3: half classes and pair products
   quad_type  quad3_ff;
   point_type query3_ff;
   half_type  cls3_ff [Corners];
   half_type  cls3_in [Corners];
   aprod_type pa3_ff [Pairs];
   aprod_type pb3_ff [Pairs];
   aprod_type pa3_in [Pairs];
   aprod_type pb3_in [Pairs];
   // stage 4: precedence matrix, less4[a][b] means a sorts before b
   quad_type                        quad4_ff;
   point_type                       query4_ff;
   logic [Corners-1:0][Corners-1:0] less4_ff, less4_in;
   across_type                      turn [Pairs];
   // stage 5: ordered corners
   quad_type  quad5_ff, quad5_in;
   point_type query5_ff;
   logic [1:0]         rank [Corners];
   logic [Corners-1:0] rank_used;

   // per-stage ready, bubbles fill while the tail waits
   always_comb begin
      rdy[Stages] = out_ready;
      for (int k = Stages - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[Stages-1];
   assign out_quad  = quad5_ff;
   assign out_query = query5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < Stages; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      sumx1_in = '0;
      sumy1_in = '0;
      for (int i = 0; i < Corners; i++) begin
         sumx1_in = sumx1_in + SumBits'(in_quad[i].x);
         sumy1_in = sumy1_in + SumBits'(in_quad[i].y);
      end
   end

   always_comb begin
      for (int i = 0; i < Corners; i++) begin
         offx2_in[i] = (OffBits'(quad1_ff[i].x) <<< 2) - OffBits'(sumx1_ff);
         offy2_in[i] = (OffBits'(quad1_ff[i].y) <<< 2) - OffBits'(sumy1_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < Corners; i++) begin
         if (offy2_ff[i][OffBits-1]) begin
            cls3_in[i] = HalfLow;
         end else if (offy2_ff[i] == '0 && !offx2_ff[i][OffBits-1]) begin
            cls3_in[i] = HalfZero;
         end else begin
            cls3_in[i] = HalfHigh;
         end
      end
      for (int p = 0; p < Pairs; p++) begin
         pa3_in[p] = AprodBits'(offx2_ff[PairLo[p]]) * AprodBits'(offy2_ff[PairHi[p]]);
         pb3_in[p] = AprodBits'(offy2_ff[PairLo[p]]) * AprodBits'(offx2_ff[PairHi[p]]);
      end
   end

   always_comb begin
      less4_in = '0;
      for (int p = 0; p < Pairs; p++) begin
         turn[p] = AcrossBits'(pa3_ff[p]) - AcrossBits'(pb3_ff[p]);
         if (cls3_ff[PairLo[p]] != cls3_ff[PairHi[p]]) begin
            less4_in[PairLo[p]][PairHi[p]] = cls3_ff[PairLo[p]] < cls3_ff[PairHi[p]];
            less4_in[PairHi[p]][PairLo[p]] = cls3_ff[PairHi[p]] < cls3_ff[PairLo[p]];
         end else if (cls3_ff[PairLo[p]] != HalfZero) begin
            less4_in[PairLo[p]][PairHi[p]] = !turn[p][AcrossBits-1] && (turn[p] != '0);
            less4_in[PairHi[p]][PairLo[p]] = turn[p][AcrossBits-1];
         end
      end
   end

   // stable rank: corners ahead plus earlier corners of equal angle
   always_comb begin
      rank_used = '0;
      quad5_in  = quad4_ff;
      for (int i = 0; i < Corners; i++) begin
         rank[i] = '0;
         for (int j = 0; j < Corners; j++) begin
            if (less4_ff[j][i]) begin
               rank[i] = rank[i] + 2'd1;
            end
            if (j < i && !less4_ff[i][j] && !less4_ff[j][i]) begin
               rank[i] = rank[i] + 2'd1;
            end
         end
      end
      for (int i = 0; i < Corners; i++) begin
         rank_used[rank[i]] = 1'b1;
         quad5_in[rank[i]]  = quad4_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         quad1_ff  <= in_quad;
         query1_ff <= in_query;
         sumx1_ff  <= sumx1_in;
         sumy1_ff  <= sumy1_in;
      end
      if (rdy[1]) begin
         quad2_ff  <= quad1_ff;
         query2_ff <= query1_ff;
         offx2_ff  <= offx2_in;
         offy2_ff  <= offy2_in;
      end
      if (rdy[2]) begin
         quad3_ff  <= quad2_ff;
         query3_ff <= query2_ff;
         cls3_ff   <= cls3_in;
         pa3_ff    <= pa3_in;
         pb3_ff    <= pb3_in;
      end
      if (rdy[3]) begin
         quad4_ff  <= quad3_ff;
         query4_ff <= query3_ff;
         less4_ff  <= less4_in;
      end
      if (rdy[4]) begin
         quad5_ff  <= quad5_in;
         query5_ff <= query4_ff;
      end
   end

   // the ranks must form a permutation of the four slots
   assert property (@(posedge clock) disable iff (reset)
      v_ff[3] |-> rank_used == '1)
      else $error("corner ranks are not a permutation");

endmodule

// File: rtl/core/pqc_edge_eval.sv
// three-stage pipeline that tests the query against the four ordered edges
module pqc_edge_eval (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  pqc_pkg::quad_type                     in_quad,
   input  pqc_pkg::point_type                    in_query,
   input  logic [pqc_pkg::CrossTolBits-1:0]      cross_tol,
   input  logic [pqc_pkg::CoordTolBits-1:0]      coord_tol,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output pqc_pkg::edge_flags_type               out_flags
);
   import pqc_pkg::*;

   localparam int Stages = 3;

   typedef logic signed [EprodBits-1:0] eprod_type;
   typedef logic signed [CrossBits-1:0] ecross_type;

   logic [Stages-1:0] v_ff;
   logic [Stages:0]   rdy;

   // stage 1: edge and query deltas, widened query box
   quad_type  quad1_ff;
   diff_type  dx1_ff [Corners];
   diff_type  dy1_ff [Corners];
   diff_type  qx1_ff [Corners];
   diff_type  qy1_ff [Corners];
   diff_type  dx1_in [Corners];
   diff_type  dy1_in [Corners];
   diff_type  qx1_in [Corners];
   diff_type  qy1_in [Corners];
   diff_type  qlox1_ff, qloy1_ff, qhix1_ff, qhiy1_ff;
   diff_type  qlox1_in, qloy1_in, qhix1_in, qhiy1_in;
   diff_type  tol_ext;
   // stage 2: edge products and box hits
   eprod_type          pa2_ff [Corners];
   eprod_type          pb2_ff [Corners];
   eprod_type          pa2_in [Corners];
   eprod_type          pb2_in [Corners];
   logic [Corners-1:0] box2_ff, box2_in;
   // stage 3: per-edge flags
   edge_flags_type flags3_ff, flags3_in;
   ecross_type     ecross [Corners];
   ecross_type     tol_wide;

   always_comb begin
      rdy[Stages] = out_ready;
      for (int k = Stages - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[Stages-1];
   assign out_flags = flags3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < Stages; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      tol_ext  = signed'(DiffBits'(coord_tol));
      qlox1_in = DiffBits'(in_query.x) - tol_ext;
      qloy1_in = DiffBits'(in_query.y) - tol_ext;
      qhix1_in = DiffBits'(in_query.x) + tol_ext;
      qhiy1_in = DiffBits'(in_query.y) + tol_ext;
      for (int e = 0; e < Corners; e++) begin
         dx1_in[e] = DiffBits'(in_quad[2'(e + 1)].x) - DiffBits'(in_quad[e].x);
         dy1_in[e] = DiffBits'(in_quad[2'(e + 1)].y) - DiffBits'(in_quad[e].y);
         qx1_in[e] = DiffBits'(in_query.x) - DiffBits'(in_quad[e].x);
         qy1_in[e] = DiffBits'(in_query.y) - DiffBits'(in_quad[e].y);
      end
   end

   // p >= min - tol is p + tol reaching either end, likewise for the max side
   always_comb begin
      for (int e = 0; e < Corners; e++) begin
         pa2_in[e]  = EprodBits'(dx1_ff[e]) * EprodBits'(qy1_ff[e]);
         pb2_in[e]  = EprodBits'(dy1_ff[e]) * EprodBits'(qx1_ff[e]);
         box2_in[e] =
            (qhix1_ff >= DiffBits'(quad1_ff[e].x) || qhix1_ff >= DiffBits'(quad1_ff[2'(e + 1)].x)) &&
            (qlox1_ff <= DiffBits'(quad1_ff[e].x) || qlox1_ff <= DiffBits'(quad1_ff[2'(e + 1)].x)) &&
            (qhiy1_ff >= DiffBits'(quad1_ff[e].y) || qhiy1_ff >= DiffBits'(quad1_ff[2'(e + 1)].y)) &&
            (qloy1_ff <= DiffBits'(quad1_ff[e].y) || qloy1_ff <= DiffBits'(quad1_ff[2'(e + 1)].y));
      end
   end

   always_comb begin
      tol_wide = signed'(CrossBits'(cross_tol));
      for (int e = 0; e < Corners; e++) begin
         ecross[e]        = CrossBits'(pa2_ff[e]) - CrossBits'(pb2_ff[e]);
         flags3_in.pos[e] = ecross[e] > tol_wide;
         flags3_in.neg[e] = ecross[e] < -tol_wide;
         flags3_in.on[e]  = !(ecross[e] > tol_wide) && !(ecross[e] < -tol_wide) && box2_ff[e];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         quad1_ff <= in_quad;
         dx1_ff   <= dx1_in;
         dy1_ff   <= dy1_in;
         qx1_ff   <= qx1_in;
         qy1_ff   <= qy1_in;
         qlox1_ff <= qlox1_in;
         qloy1_ff <= qloy1_in;
         qhix1_ff <= qhix1_in;
         qhiy1_ff <= qhiy1_in;
      end
      if (rdy[1]) begin
         pa2_ff  <= pa2_in;
         pb2_ff  <= pb2_in;
         box2_ff <= box2_in;
      end
      if (rdy[2]) begin
         flags3_ff <= flags3_in;
      end
   end

   // an edge is on, positive, negative or none of them, never two at once
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> ((flags3_ff.pos & flags3_ff.neg) == '0) &&
                    ((flags3_ff.on & (flags3_ff.pos | flags3_ff.neg)) == '0))
      else $error("edge flags overlap");

endmodule

// File: rtl/core/point_in_quad_classifier_core.sv
// top level of the point-in-quad classifier: registers, pipelines and result word
//
//  channel | ports                              | direction | word
//  --------+------------------------------------+-----------+-------------------------------
//  req     | req_valid / req_ready              | in        | four corners, query, Q16.16
//  rsp     | rsp_valid / rsp_ready              | out       | placement: outside/inside/edge
//  csr     | csr_write / csr_index / csr_wdata  | in        | cross and coord tolerances
//
//  one word per cycle is taken and delivered unless rsp_ready stalls the pipeline
//  path: 5 stages of angle sort (35x35 cross products), 3 of edge test, 1 output register
//  every stage has its own valid and ready, so bubbles close up behind a stalled rsp
//  synchronous active-high reset empties the pipeline and clears both tolerances to zero
//  tolerance writes take effect at once; write them only while the pipeline is empty
module point_in_quad_classifier_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  pqc_pkg::coord_type                 req_corner0_x,
   input  pqc_pkg::coord_type                 req_corner0_y,
   input  pqc_pkg::coord_type                 req_corner1_x,
   input  pqc_pkg::coord_type                 req_corner1_y,
   input  pqc_pkg::coord_type                 req_corner2_x,
   input  pqc_pkg::coord_type                 req_corner2_y,
   input  pqc_pkg::coord_type                 req_corner3_x,
   input  pqc_pkg::coord_type                 req_corner3_y,
   input  pqc_pkg::coord_type                 req_query_x,
   input  pqc_pkg::coord_type                 req_query_y,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pqc_pkg::PlaceBits-1:0]      rsp_placement,
   input  logic                               csr_write,
   input  logic [pqc_pkg::CsrIndexBits-1:0]   csr_index,
   input  logic [pqc_pkg::CsrDataBits-1:0]    csr_wdata
);
   import pqc_pkg::*;

   // tolerance registers
   logic [CrossTolBits-1:0] cross_tol_ff;
   logic [CoordTolBits-1:0] coord_tol_ff;

   // request word as a quad
   quad_type  req_quad;
   point_type req_query;

   // sort to edge stage
   logic      sort_valid, sort_ready;
   quad_type  sort_quad;
   point_type sort_query;

   // edge stage to result
   logic           edge_valid, edge_ready;
   edge_flags_type edge_flags;

   // edge walk
   logic walk_done, seen_pos, seen_neg;

   // output register
   logic                 rsp_valid_ff;
   logic [PlaceBits-1:0] rsp_placement_ff, rsp_placement_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cross_tol_ff <= '0;
         coord_tol_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrCrossTol: begin
               cross_tol_ff <= csr_wdata[CrossTolBits-1:0];
            end
            CsrCoordTol: begin
               coord_tol_ff <= csr_wdata[CoordTolBits-1:0];
            end
         endcase
      end
   end

   always_comb begin
      req_quad[0].x = req_corner0_x;
      req_quad[0].y = req_corner0_y;
      req_quad[1].x = req_corner1_x;
      req_quad[1].y = req_corner1_y;
      req_quad[2].x = req_corner2_x;
      req_quad[2].y = req_corner2_y;
      req_quad[3].x = req_corner3_x;
      req_quad[3].y = req_corner3_y;
      req_query.x   = req_query_x;
      req_query.y   = req_query_y;
   end

   // corners come out in angle order around the centroid, stable on ties
   pqc_angle_sort u_sort (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_quad   (req_quad),
      .in_query  (req_query),
      .out_valid (sort_valid),
      .out_ready (sort_ready),
      .out_quad  (sort_quad),
      .out_query (sort_query)
   );

   // on-edge, positive-side and negative-side flags for each ordered edge
   pqc_edge_eval u_edge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sort_valid),
      .in_ready  (sort_ready),
      .in_quad   (sort_quad),
      .in_query  (sort_query),
      .cross_tol (cross_tol_ff),
      .coord_tol (coord_tol_ff),
      .out_valid (edge_valid),
      .out_ready (edge_ready),
      .out_flags (edge_flags)
   );

   // walk edges in order: on-edge wins at once, both sides seen means outside
   always_comb begin
      rsp_placement_in = PlaceInside;
      walk_done        = 1'b0;
      seen_pos         = 1'b0;
      seen_neg         = 1'b0;
      for (int e = 0; e < Corners; e++) begin
         if (!walk_done) begin
            if (edge_flags.on[e]) begin
               rsp_placement_in = PlaceOnEdge;
               walk_done        = 1'b1;
            end else begin
               seen_pos = seen_pos | edge_flags.pos[e];
               seen_neg = seen_neg | edge_flags.neg[e];
               if (seen_pos && seen_neg) begin
                  rsp_placement_in = PlaceOutside;
                  walk_done        = 1'b1;
               end
            end
         end
      end
   end

   // output register parts the pipeline from the consumer
   assign edge_ready    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_placement = rsp_placement_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (edge_ready) begin
         rsp_valid_ff <= edge_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (edge_ready) begin
         rsp_placement_ff <= rsp_placement_in;
      end
   end

   // the first edge holding the point always decides on-edge
   assert property (@(posedge clock) disable iff (reset)
      (edge_valid && edge_ready && edge_flags.on[0]) |=> rsp_placement_ff == PlaceOnEdge)
      else $error("first edge hit not reported as on edge");

   // no edge hit and no negative side leaves the point inside
   assert property (@(posedge clock) disable iff (reset)
      (edge_valid && edge_ready && edge_flags.on == '0 && edge_flags.neg == '0)
      |=> rsp_placement_ff == PlaceInside)
      else $error("one-sided walk not reported as inside");

   // a result word only appears when the edge stage handed one over
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(edge_valid))
      else $error("result word without a source");

endmodule

// File: tb/point_in_quad_classifier_core_tb.sv
// self-checking testbench for the point-in-quad classifier core
module point_in_quad_classifier_core_tb;
   import pqc_pkg::*;

   // one request word: four corners then the query point
   typedef struct packed {
      quad_type  corner;
      point_type query;
   } query_word_type;

   // wide enough for every exact product the classifier forms
   typedef logic signed [127:0] wide_type;

   localparam longint One          = 65536;
   localparam longint Half         = 32768;
   localparam longint CoordMax     = 2147483647;
   localparam longint CoordMin     = -CoordMax - 1;
   localparam int     DrainCycles  = 12;
   localparam int     LimitCycles  = 500000;
   localparam int     RandomPhases = 7;
   localparam int     WordsPerPhase = 105;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   query_word_type          req_word;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [PlaceBits-1:0]    rsp_placement;
   logic                    csr_write;
   logic [CsrIndexBits-1:0] csr_index;
   logic [CsrDataBits-1:0]  csr_wdata;

   // tolerances as the block should hold them right now
   logic [CrossTolBits-1:0] cross_tol_now;
   logic [CoordTolBits-1:0] coord_tol_now;

   // placements still owed by the block, oldest first
   logic [PlaceBits-1:0]    pending_placements[$];
   logic [PlaceBits-1:0]    due_placement;

   bit     source_gaps;
   bit     sink_stalls;
   int     stall_left;
   int     errors;
   int     words_checked;
   int     settings_used;
   int     placement_seen[4];
   longint cycle_count;

   point_in_quad_classifier_core uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_corner0_x (req_word.corner[0].x),
      .req_corner0_y (req_word.corner[0].y),
      .req_corner1_x (req_word.corner[1].x),
      .req_corner1_y (req_word.corner[1].y),
      .req_corner2_x (req_word.corner[2].x),
      .req_corner2_y (req_word.corner[2].y),
      .req_corner3_x (req_word.corner[3].x),
      .req_corner3_y (req_word.corner[3].y),
      .req_query_x   (req_word.query.x),
      .req_query_y   (req_word.query.y),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_placement (rsp_placement),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // placement predictor
   // ---------------------------------------------------------------------------

   // 0: below the x axis, 1: exactly on the positive x axis (or zero vector), 2: the rest
   function automatic int half_plane(input longint dx, input longint dy);
      if (dy < 0) return 0;
      if (dy == 0 && dx >= 0) return 1;
      return 2;
   endfunction

   // strict angle order of two centroid offsets, as atan2 would rank them
   function automatic bit angle_before(input longint ax, input longint ay,
                                       input longint bx, input longint by);
      int       ha;
      int       hb;
      wide_type turn;
      ha = half_plane(ax, ay);
      hb = half_plane(bx, by);
      if (ha != hb) return ha < hb;
      if (ha == 1) return 1'b0;
      turn = wide_type'(ax) * wide_type'(by) - wide_type'(ay) * wide_type'(bx);
      return turn > 0;
   endfunction

   function automatic logic [PlaceBits-1:0] classify_placement(
         input query_word_type w,
         input logic [CrossTolBits-1:0] area_tol,
         input logic [CoordTolBits-1:0] box_tol);
      longint   x[Corners];
      longint   y[Corners];
      longint   sx[Corners];
      longint   sy[Corners];
      longint   px, py, sumx, sumy, slack, area_lim, lox, hix, loy, hiy;
      int       ord[Corners];
      int       cur, k, a, b;
      wide_type area, mag;
      bit       seen_pos, seen_neg;
      sumx     = 0;
      sumy     = 0;
      seen_pos = 1'b0;
      seen_neg = 1'b0;
      slack    = box_tol;
      area_lim = area_tol;
      px       = w.query.x;
      py       = w.query.y;
      for (int i = 0; i < Corners; i++) begin
         x[i]   = w.corner[i].x;
         y[i]   = w.corner[i].y;
         sumx  += x[i];
         sumy  += y[i];
         ord[i] = i;
      end
      // offsets from the centroid, scaled by four to stay integral
      for (int i = 0; i < Corners; i++) begin
         sx[i] = 4 * x[i] - sumx;
         sy[i] = 4 * y[i] - sumy;
      end
      // insertion sort keeps equal angles in input order
      for (int i = 1; i < Corners; i++) begin
         cur = ord[i];
         k   = i;
         while (k > 0 && angle_before(sx[cur], sy[cur], sx[ord[k-1]], sy[ord[k-1]])) begin
            ord[k] = ord[k-1];
            k--;
         end
         ord[k] = cur;
      end
      // walk the edges; first on-edge hit wins, both sides seen means outside
      for (int i = 0; i < Corners; i++) begin
         a    = ord[i];
         b    = ord[(i + 1) % Corners];
         area = wide_type'(x[b] - x[a]) * wide_type'(py - y[a])
              - wide_type'(y[b] - y[a]) * wide_type'(px - x[a]);
         mag  = (area < 0) ? -area : area;
         if (mag <= area_lim) begin
            lox = (x[a] < x[b]) ? x[a] : x[b];
            hix = (x[a] < x[b]) ? x[b] : x[a];
            loy = (y[a] < y[b]) ? y[a] : y[b];
            hiy = (y[a] < y[b]) ? y[b] : y[a];
            if (px >= lox - slack && px <= hix + slack &&
                py >= loy - slack && py <= hiy + slack)
               return PlaceOnEdge;
         end else if (area < 0) begin
            seen_neg = 1'b1;
         end else begin
            seen_pos = 1'b1;
         end
         if (seen_pos && seen_neg) return PlaceOutside;
      end
      return PlaceInside;
   endfunction

   // ---------------------------------------------------------------------------
   // scoreboard: predict on every accepted word, compare on every delivered word
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_placements.size() == 0) begin
               $display("%0t: placement word with nothing outstanding, expected none, actual %0d",
                        $time, rsp_placement);
               errors++;
            end else begin
               due_placement = pending_placements.pop_front();
               if (rsp_placement !== due_placement) begin
                  $display("%0t: placement mismatch, expected %0d, actual %0d",
                           $time, due_placement, rsp_placement);
                  errors++;
               end
               words_checked++;
            end
         end
         if (req_valid && req_ready) begin
            due_placement = classify_placement(req_word, cross_tol_now, coord_tol_now);
            pending_placements.push_back(due_placement);
            placement_seen[due_placement]++;
         end
      end
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LimitCycles) begin
         $display("%0t: cycle limit reached with %0d placements outstanding",
                  $time, pending_placements.size());
         $display("status: fail");
         $finish;
      end
   end

   // mostly short idle stretches, now and then a long one
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side back-pressure, changed on the falling edge
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 99) < 20) begin
         stall_left = idle_length();
         rsp_ready  = 1'b0;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------------

   // present one word and hold it until the block takes it
   task automatic send_word(input query_word_type w);
      int gap;
      gap = source_gaps ? idle_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word  = w;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid, let every owed placement arrive, then idle for DrainCycles
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_placements.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_tolerance(input logic [CsrIndexBits-1:0] idx,
                                  input logic [CsrDataBits-1:0]  data);
      wait_idle();
      csr_index = idx;
      csr_wdata = data;
      csr_write = 1'b1;
      @(negedge clock);
      csr_write = 1'b0;
      // only the low bits of the coord register are kept
      if (idx == CsrCrossTol) cross_tol_now = data;
      else                    coord_tol_now = data[CoordTolBits-1:0];
   endtask

   task automatic set_tolerances(input logic [CrossTolBits-1:0] area_tol,
                                 input logic [CsrDataBits-1:0]  box_word);
      write_tolerance(CsrCrossTol, area_tol);
      write_tolerance(CsrCoordTol, box_word);
      settings_used++;
   endtask

   // ---------------------------------------------------------------------------
   // word builders
   // ---------------------------------------------------------------------------
   function automatic query_word_type make_word(input longint x0, input longint y0,
                                                input longint x1, input longint y1,
                                                input longint x2, input longint y2,
                                                input longint x3, input longint y3,
                                                input longint qx, input longint qy);
      query_word_type w;
      w.corner[0].x = coord_type'(x0);
      w.corner[0].y = coord_type'(y0);
      w.corner[1].x = coord_type'(x1);
      w.corner[1].y = coord_type'(y1);
      w.corner[2].x = coord_type'(x2);
      w.corner[2].y = coord_type'(y2);
      w.corner[3].x = coord_type'(x3);
      w.corner[3].y = coord_type'(y3);
      w.query.x     = coord_type'(qx);
      w.query.y     = coord_type'(qy);
      return w;
   endfunction

   // unit square with its corners given out of angle order
   function automatic query_word_type unit_square(input longint qx, input longint qy);
      return make_word(0, 0, One, One, One, 0, 0, One, qx, qy);
   endfunction

   function automatic longint spread(input longint r);
      return longint'($urandom_range(0, 32'(2 * r))) - r;
   endfunction

   // even lengths keep edge midpoints of kites and rectangles exact
   function automatic longint even_len(input longint span);
      return 2 * longint'($urandom_range(1, 32'(span / 2)));
   endfunction

   // a well-formed quad (kite, rectangle or loose cloud) shuffled, with a query near the
   // interesting spots (center, corners, edge midpoints and around them) or anywhere wider
   function automatic query_word_type random_quad_word();
      query_word_type w;
      longint gx[Corners];
      longint gy[Corners];
      longint cx, cy, span, qx, qy, ea, eb, ec, ed;
      int     perm[Corners];
      int     j, t, k, m;
      span = longint'(1) << (($urandom_range(0, 9) == 0) ? $urandom_range(21, 27)
                                                          : $urandom_range(4, 20));
      cx = spread(longint'(1) << 28);
      cy = spread(longint'(1) << 28);
      ea = even_len(span);
      eb = even_len(span);
      ec = even_len(span);
      ed = even_len(span);
      case ($urandom_range(0, 2))
         0: begin
            gx[0] = cx + ea; gy[0] = cy;
            gx[1] = cx;      gy[1] = cy + eb;
            gx[2] = cx - ec; gy[2] = cy;
            gx[3] = cx;      gy[3] = cy - ed;
         end
         1: begin
            gx[0] = cx + ea; gy[0] = cy + eb;
            gx[1] = cx - ec; gy[1] = cy + eb;
            gx[2] = cx - ec; gy[2] = cy - ed;
            gx[3] = cx + ea; gy[3] = cy - ed;
         end
         default: begin
            for (int i = 0; i < Corners; i++) begin
               gx[i] = cx + spread(span);
               gy[i] = cy + spread(span);
            end
         end
      endcase
      k = $urandom_range(0, Corners - 1);
      m = (k + 1) % Corners;
      case ($urandom_range(0, 5))
         0: begin
            qx = cx + spread(span / 8);
            qy = cy + spread(span / 8);
         end
         1: begin
            qx = gx[k];
            qy = gy[k];
         end
         2: begin
            qx = (gx[k] + gx[m]) / 2;
            qy = (gy[k] + gy[m]) / 2;
         end
         3: begin
            qx = (gx[k] + gx[m]) / 2 + spread(3);
            qy = (gy[k] + gy[m]) / 2 + spread(3);
         end
         4: begin
            qx = cx + spread(2 * span);
            qy = cy + spread(2 * span);
         end
         default: begin
            qx = longint'(int'($urandom()));
            qy = longint'(int'($urandom()));
         end
      endcase
      for (int i = 0; i < Corners; i++) perm[i] = i;
      for (j = Corners - 1; j > 0; j--) begin
         t       = $urandom_range(0, j);
         k       = perm[j];
         perm[j] = perm[t];
         perm[t] = k;
      end
      for (int i = 0; i < Corners; i++) begin
         w.corner[i].x = coord_type'(gx[perm[i]]);
         w.corner[i].y = coord_type'(gy[perm[i]]);
      end
      w.query.x = coord_type'(qx);
      w.query.y = coord_type'(qy);
      return w;
   endfunction

   function automatic coord_type noise_coord(input bit tiny, input longint scale);
      if (tiny) return coord_type'((longint'($urandom_range(0, 6)) - 3) * scale);
      return coord_type'($urandom());
   endfunction

   // unstructured words: full-range bits, or a tiny grid that piles up
   // repeated corners, collinear sets and equal angles
   function automatic query_word_type noise_word();
      query_word_type w;
      bit             tiny;
      longint         scale;
      tiny  = 1'($urandom_range(0, 1));
      scale = $urandom_range(0, 1) ? 1 : One;
      for (int i = 0; i < Corners; i++) begin
         w.corner[i].x = noise_coord(tiny, scale);
         w.corner[i].y = noise_coord(tiny, scale);
      end
      w.query.x = noise_coord(tiny, scale);
      w.query.y = noise_coord(tiny, scale);
      return w;
   endfunction

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // hand-picked shapes at the reset tolerances of zero
   task automatic test_directed_shapes();
      send_word(unit_square(Half, Half));
      send_word(unit_square(2 * One, Half));
      send_word(unit_square(Half, 0));
      send_word(unit_square(One, One));
      send_word(unit_square(Half, -1));
      // kite, query at the center and on a slanted edge
      send_word(make_word(2 * One, 0, 0, One, -2 * One, 0, 0, -One, 0, 0));
      send_word(make_word(2 * One, 0, 0, One, -2 * One, 0, 0, -One, One, Half));
      // all four corners on one spot
      send_word(make_word(5, 5, 5, 5, 5, 5, 5, 5, 5, 5));
      send_word(make_word(5, 5, 5, 5, 5, 5, 5, 5, 6, 5));
      // all corners on one line
      send_word(make_word(0, 0, One, 0, 2 * One, 0, 3 * One, 0, Half, 0));
      send_word(make_word(0, 0, One, 0, 2 * One, 0, 3 * One, 0, Half, One));
      // one corner sits exactly on the centroid
      send_word(make_word(0, 0, 3 * One, 0, 0, 3 * One, One, One, Half, Half));
      // two corners share an angle, input order must survive the sort
      send_word(make_word(One, 0, 2 * One, 0, -3 * One, One, -3 * One, -One, 0, 0));
      // full-scale square, scrambled corners
      send_word(make_word(CoordMax, CoordMax, CoordMin, CoordMin, CoordMax, CoordMin,
                          CoordMin, CoordMax, 0, 0));
      send_word(make_word(CoordMax, CoordMax, CoordMin, CoordMin, CoordMax, CoordMin,
                          CoordMin, CoordMax, CoordMax, CoordMax));
      send_word(make_word(CoordMax, CoordMax, CoordMin, CoordMin, CoordMax, CoordMin,
                          CoordMin, CoordMax, CoordMin, 0));
      // repeated corner turns the quad into a triangle
      send_word(make_word(0, 0, One, 0, One, 0, 0, One, One / 4, One / 4));
   endtask

   // points just off the unit square, at both ends of each tolerance
   task automatic test_tolerance_edges();
      set_tolerances(32'hFFFF_FFFF, 32'h0000_FFFF);
      send_word(unit_square(Half, -65535));
      send_word(unit_square(Half, -65536));
      send_word(unit_square(One + 65535, 0));
      send_word(unit_square(One + 65536, 0));
      set_tolerances(32'd1, 32'd1);
      send_word(unit_square(One + 1, 0));
      send_word(unit_square(One + 2, 0));
      send_word(unit_square(Half, -1));
      send_word(unit_square(0, -1));
   endtask

   // phases of random words, each under its own tolerance pair and idling mix
   task automatic test_random_quads();
      logic [CrossTolBits-1:0] area_tol;
      logic [CsrDataBits-1:0]  box_word;
      for (int p = 0; p < RandomPhases; p++) begin
         // phase 1 runs back to back, others idle on one or both sides
         source_gaps = (p != 1 && p != 6);
         sink_stalls = (p != 1 && p != 5);
         case (p)
            0: begin
               area_tol = '0;
               box_word = '0;
            end
            1: begin
               area_tol = '1;
               box_word = 32'h0000_FFFF;
            end
            2: begin
               area_tol = $urandom();
               box_word = $urandom();
            end
            3: begin
               area_tol = $urandom_range(0, 1 << 24);
               box_word = ($urandom() & 32'hFFFF_0000) | $urandom_range(0, 16);
            end
            4: begin
               area_tol = '0;
               box_word = 32'h0000_FFFF;
            end
            5: begin
               area_tol = '1;
               box_word = '0;
            end
            default: begin
               area_tol = $urandom_range(1 << 16, 1 << 30);
               box_word = $urandom_range(0, 255);
            end
         endcase
         set_tolerances(area_tol, box_word);
         repeat (WordsPerPhase) begin
            if ($urandom_range(0, 3) != 0) send_word(random_quad_word());
            else                           send_word(noise_word());
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_word      = '0;
      rsp_ready     = 1'b0;
      csr_write     = 1'b0;
      csr_index     = CsrCrossTol;
      csr_wdata     = '0;
      cross_tol_now = '0;
      coord_tol_now = '0;
      source_gaps   = 1'b1;
      sink_stalls   = 1'b1;
      stall_left    = 0;
      errors        = 0;
      words_checked = 0;
      settings_used = 1;
      cycle_count   = 0;
      placement_seen = '{0, 0, 0, 0};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_shapes();
      test_tolerance_edges();
      test_random_quads();
      wait_idle();

      $display("covered %0d classified words under %0d tolerance settings",
               words_checked, settings_used);
      $display("mix of answers: outside %0d, inside %0d, on edge %0d",
               placement_seen[PlaceOutside], placement_seen[PlaceInside],
               placement_seen[PlaceOnEdge]);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/pqc_pkg.sv
rtl/core/pqc_angle_sort.sv
rtl/core/pqc_edge_eval.sv
rtl/core/point_in_quad_classifier_core.sv
tb/point_in_quad_classifier_core_tb.sv
